// ===== hw/rtl/grs_pkg.sv =====
// Shared types, constants and state encoding for the Golomb ruler subtree search.
`timescale 1ns / 1ps
`default_nettype none
package grs_pkg;
  localparam int MAX_MARKS_DEF = 24;
  localparam int MAX_LENGTH_DEF = 127;
  localparam int OUT_CAP = 24;
  localparam logic [4:0] MARKS_WANTED_RST = 5'd10;
  localparam logic [6:0] LENGTH_LIMIT_RST = 7'd127;
  localparam logic [0:0] REG_MARKS_WANTED = 1'b0;
  localparam logic [0:0] REG_LENGTH_LIMIT = 1'b1;

  typedef struct packed {
    logic [63:0] marks_low;
    logic [63:0] marks_high;
    logic [63:0] dist_low;
    logic [63:0] dist_high;
    logic [4:0]  marks_placed;
    logic [6:0]  prefix_length;
    logic        restart;
  } in_word_t;

  typedef struct packed {
    logic        improved;
    logic [7:0]  best_length;
    logic [6:0]  mark_position;
    logic [4:0]  mark_index;
    logic [31:0] nodes_explored;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ENTRY, ST_LOAD, ST_FRAME, ST_SCAN, ST_POP, ST_EMIT_SCAN, ST_EMIT_WAIT,
    ST_SINGLE
  } state_t;

  typedef struct packed {
    logic load;
    logic entry_ok;
    logic frame_start;
    logic scan_step;
    logic pop;
    logic emit_init;
    logic emit_step;
    logic out_load;
    logic out_single;
  } cmd_t;

  typedef struct packed {
    logic entry_pass;
    logic frame_prune;
    logic scan_end;
    logic scan_push;
    logic stack_empty;
    logic improved;
    logic emit_hit;
    logic emit_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/grs_ctrl.sv =====
// Controller state machine sequencing entry check, search walk and result emission.
`timescale 1ns / 1ps
`default_nettype none
module grs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_take,
  input  wire logic           out_busy,
  input  wire grs_pkg::stat_t st,
  output grs_pkg::cmd_t       cmd,
  output logic                idle
);
  grs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= grs_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      grs_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_take) begin
          cmd.load = 1'b1;
          state_next = grs_pkg::ST_ENTRY;
        end
      end
      grs_pkg::ST_ENTRY: begin
        if (st.entry_pass) begin
          cmd.entry_ok = 1'b1;
          state_next = grs_pkg::ST_FRAME;
        end else state_next = grs_pkg::ST_SINGLE;
      end
      grs_pkg::ST_LOAD: state_next = grs_pkg::ST_FRAME;
      grs_pkg::ST_FRAME: begin
        cmd.frame_start = 1'b1;
        if (st.frame_prune) state_next = grs_pkg::ST_POP;
        else state_next = grs_pkg::ST_SCAN;
      end
      grs_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_push) state_next = grs_pkg::ST_LOAD;
        else if (st.scan_end) state_next = grs_pkg::ST_POP;
      end
      grs_pkg::ST_POP: begin
        cmd.pop = 1'b1;
        if (!st.stack_empty) state_next = grs_pkg::ST_LOAD;
        else if (st.improved) begin
          cmd.emit_init = 1'b1;
          state_next = grs_pkg::ST_EMIT_SCAN;
        end else state_next = grs_pkg::ST_SINGLE;
      end
      grs_pkg::ST_EMIT_SCAN: begin
        if (!out_busy) begin
          cmd.emit_step = 1'b1;
          if (st.emit_hit) begin
            cmd.out_load = 1'b1;
            if (st.emit_done) state_next = grs_pkg::ST_EMIT_WAIT;
          end else if (st.emit_done) state_next = grs_pkg::ST_EMIT_WAIT;
        end
      end
      grs_pkg::ST_EMIT_WAIT: if (!out_busy) state_next = grs_pkg::ST_IDLE;
      grs_pkg::ST_SINGLE: begin
        if (!out_busy) begin
          cmd.out_single = 1'b1;
          state_next = grs_pkg::ST_IDLE;
        end
      end
      default: state_next = grs_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/grs_datapath.sv =====
// Search datapath: frame stack memory, candidate tester, best ruler and output register.
`timescale 1ns / 1ps
`default_nettype none
module grs_datapath #(
  parameter int MAX_MARKS = grs_pkg::MAX_MARKS_DEF,
  parameter int MAX_LENGTH = grs_pkg::MAX_LENGTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire grs_pkg::in_word_t in_word,
  input  wire logic [4:0]        marks_wanted,
  input  wire logic [6:0]        length_limit,
  input  wire grs_pkg::cmd_t     cmd,
  input  wire logic              out_stall,
  output grs_pkg::stat_t         st,
  output logic                   out_valid,
  output grs_pkg::out_word_t     out_word
);
  localparam int DW = $clog2(MAX_MARKS);
  localparam logic [4:0] NMAX = 5'(MAX_MARKS > 31 ? 31 : MAX_MARKS);
  localparam logic [6:0] LMAX = 7'(MAX_LENGTH);

  typedef struct packed {
    logic [127:0] marks;
    logic [127:0] used;
    logic [4:0]   count;
    logic [6:0]   len;
    logic [7:0]   nxt;
  } frame_t;

  frame_t mem [MAX_MARKS];
  frame_t cur, rd;
  logic [DW:0] top;
  logic [7:0] best;
  logic [127:0] best_marks;
  logic [31:0] nodes;
  logic improved;
  logic [4:0] n;
  logic [9:0] bound;
  logic [8:0] rbound1;
  logic [7:0] pos;
  logic [7:0] eidx;
  logic [4:0] k;
  logic rd_pending;

  function automatic logic [8:0] tri_f(input logic [5:0] r);
    logic [11:0] p;
    p = 12'(r) * 12'(r + 6'd1);
    return 9'(p >> 1);
  endfunction

  assign n = (marks_wanted > NMAX) ? NMAX : marks_wanted;

  logic [5:0] r_cur;
  logic [127:0] shifted, sh_use;
  logic conflict;
  assign r_cur = 6'(n) - 6'(cur.count);
  assign bound = 10'(cur.len) + 10'(tri_f(r_cur));
  assign rbound1 = tri_f(r_cur - 6'd1);
  assign shifted = cur.marks << (pos - 8'(cur.len));
  assign sh_use = shifted;
  assign conflict = |(sh_use & cur.used);

  logic [5:0] r_in;
  logic [9:0] ent_b;
  assign r_in = 6'(n) - 6'(in_word.marks_placed);
  assign ent_b = 10'(in_word.prefix_length) + 10'(tri_f(r_in));

  logic scan_fin, complete, push_ok;
  assign scan_fin = (10'(pos) + 10'(rbound1) + 10'd1) > 10'(best);
  assign complete = (5'(cur.count + 5'd1) == n);
  assign push_ok = (32'(top) + 32'd1 < 32'(MAX_MARKS));

  always_comb begin
    st = '0;
    st.entry_pass = (in_word.marks_placed < n) && (ent_b < 10'(best));
    st.frame_prune = (bound >= 10'(best));
    st.scan_end = scan_fin;
    st.scan_push = !scan_fin && !conflict && !complete && push_ok;
    st.stack_empty = (top == '0);
    st.improved = improved;
    st.emit_hit = best_marks[7'(best - eidx)];
    st.emit_done = (eidx == best) || (eidx == 8'd127) ||
                   (st.emit_hit && k == 5'(grs_pkg::OUT_CAP - 1));
  end

  logic [DW-1:0] top_i;
  assign top_i = top[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= 8'd128;
      best_marks <= '0;
    end else if (cmd.load && in_word.restart) begin
      best <= 8'((length_limit > LMAX ? LMAX : length_limit)) + 8'd1;
      best_marks <= '0;
    end else if (cmd.scan_step && !scan_fin && !conflict && complete) begin
      best <= pos;
      best_marks <= sh_use | 128'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      improved <= 1'b0;
      nodes <= '0;
      top <= '0;
    end
    if (cmd.entry_ok) begin
      cur.marks <= {in_word.marks_high, in_word.marks_low};
      cur.used <= {in_word.dist_high, in_word.dist_low};
      cur.count <= in_word.marks_placed;
      cur.len <= in_word.prefix_length;
      cur.nxt <= 8'(in_word.prefix_length) + 8'd1;
    end
    if (rd_pending) begin
      cur <= rd;
    end
    if (cmd.frame_start) begin
      if (nodes != '1) nodes <= nodes + 32'd1;
      pos <= cur.nxt;
    end
    if (cmd.scan_step && !scan_fin) begin
      pos <= pos + 8'd1;
      if (!conflict) begin
        if (complete) begin
          improved <= 1'b1;
        end else if (push_ok) begin
          mem[top_i] <= '{cur.marks, cur.used, cur.count, cur.len, pos + 8'd1};
          cur <= '{sh_use | 128'd1, cur.used ^ sh_use, cur.count + 5'd1, 7'(pos), pos + 8'd1};
          top <= top + 1'b1;
        end
      end
    end
    if (cmd.pop && top != '0) begin
      rd <= mem[DW'(top - 1'b1)];
      top <= top - 1'b1;
    end
    if (cmd.emit_init) begin
      eidx <= '0;
      k <= '0;
    end
    if (cmd.emit_step) begin
      eidx <= eidx + 8'd1;
      if (st.emit_hit) k <= k + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pending <= 1'b0;
    else rd_pending <= cmd.pop && top != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load || cmd.out_single) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= '{1'b1, best, 7'(eidx), k, nodes, st.emit_done};
    end else if (cmd.out_single) begin
      out_word <= '{improved, best, 7'd0, 5'd0, nodes, 1'b1};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/golomb_ruler_subtree_search_core.sv =====
// Top level of the Golomb ruler subtree search core.
// Run time depends on the data: it grows with the frames visited and the candidate
// positions scanned, then results are emitted by walking the bits of the best ruler.
// Throughput: one input word at a time; the next is taken after its last result word.
// The frame stack memory and the single candidate tester set the rate.
// Reset (rst, synchronous) restores config, state, out_valid, and best length to 128.
`timescale 1ns / 1ps
`default_nettype none
module golomb_ruler_subtree_search_core #(
  parameter int MAX_MARKS = grs_pkg::MAX_MARKS_DEF,
  parameter int MAX_LENGTH = grs_pkg::MAX_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire grs_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output grs_pkg::out_word_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);
  logic [4:0] marks_wanted;
  logic [6:0] length_limit;
  grs_pkg::cmd_t cmd;
  grs_pkg::stat_t st;
  grs_pkg::in_word_t in_reg;
  logic idle, out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks_wanted <= grs_pkg::MARKS_WANTED_RST;
      length_limit <= grs_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grs_pkg::REG_MARKS_WANTED: marks_wanted <= cfg_data[4:0];
        grs_pkg::REG_LENGTH_LIMIT: length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !idle;
  always_ff @(posedge clk) if (in_valid && idle) in_reg <= in_data;
  assign out_busy = out_valid && out_stall;

  grs_pkg::in_word_t dp_in;
  assign dp_in = cmd.load ? in_data : in_reg;

  grs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_take(in_valid && idle), .out_busy(out_busy),
    .st(st), .cmd(cmd), .idle(idle)
  );

  grs_datapath #(.MAX_MARKS(MAX_MARKS), .MAX_LENGTH(MAX_LENGTH)) u_dp (
    .clk(clk), .rst(rst), .in_word(dp_in), .marks_wanted(marks_wanted),
    .length_limit(length_limit), .cmd(cmd), .out_stall(out_stall), .st(st),
    .out_valid(out_valid), .out_word(out_data)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !idle |-> in_stall) else $error("input taken while busy");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_load && cmd.out_single)) else $error("two output loads");
endmodule
`default_nettype wire
